// ===== src/lgfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgfs_pkg: shared types and constants for the led gate frame shifter
// Frame layout constants, default chain sizes and the input word type.
// ----------------------------------------------------------------------------
package lgfs_pkg;

    localparam int LED_COUNT_DEF  = 16;
    localparam int GATE_COUNT_DEF = 6;

    localparam logic [7:0] PHASE_STEP     = 8'd16;
    localparam logic [3:0] SYNC_GATE_BASE = 4'd3;
    localparam logic [1:0] SYNC_NONE      = 2'd3;

    localparam int GATE_SUCCESS = 0;
    localparam int GATE_ERROR   = 1;
    localparam int GATE_FIRST_SYNC = 3;

    typedef struct packed {
        logic [7:0] progress;
        logic [1:0] sync_index;
        logic [7:0] byte_count_low;
        logic       error_flag;
        logic       success_flag;
    } t_item;

endpackage

// ===== src/led_gate_frame_shifter_unit.sv =====
// ----------------------------------------------------------------------------
// led_gate_frame_shifter_unit: gate lamp and pwm led frame shifter
// Each accepted word is held in an input register, turned into a whole frame
// in one pass and shifted out one bit per cycle while i_stall is low, latch
// flag on the last bit. After acceptance the word passes from the input
// register into the frame shift register before its first bit appears, and
// a new word is taken while the current frame is still shifting.
// Synchronous active-low reset clears frame count, pwm phase and all valids.
// ----------------------------------------------------------------------------
module led_gate_frame_shifter_unit #(
    parameter int LED_COUNT  = lgfs_pkg::LED_COUNT_DEF,
    parameter int GATE_COUNT = lgfs_pkg::GATE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_progress,
    input  logic [1:0] i_sync_index,
    input  logic [7:0] i_byte_count_low,
    input  logic       i_error_flag,
    input  logic       i_success_flag,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_serial_bit,
    output logic       o_latch_after
);
    import lgfs_pkg::*;

    localparam int FrameW = GATE_COUNT + LED_COUNT;
    localparam int LeftW  = $clog2(FrameW + 1);

    t_item              r_item;
    logic               r_in_valid;
    logic               n_in_valid;
    logic [FrameW-1:0]  r_frame;
    logic [FrameW-1:0]  n_frame;
    logic [LeftW-1:0]   r_left;
    logic [LeftW-1:0]   n_left;
    logic [7:0]         r_frame_cnt;
    logic [7:0]         n_frame_cnt;
    logic [7:0]         r_phase;
    logic [7:0]         n_phase;

    logic               out_take;
    logic               frame_free;
    logic               load;
    logic               accept;
    logic [7:0]         base;
    logic [FrameW-1:0]  built;

    assign o_valid       = (r_left != '0);
    assign o_serial_bit  = r_frame[0];
    assign o_latch_after = (r_left == LeftW'(1));

    assign out_take   = o_valid & ~i_stall;
    assign frame_free = (r_left == '0) | ((r_left == LeftW'(1)) & out_take);
    assign load       = r_in_valid & frame_free;
    assign o_stall    = r_in_valid & ~load;
    assign accept     = i_valid & ~o_stall;

    // frame build for the word in the input register
    always_comb begin
        built = '1;
        base  = r_item.byte_count_low + {r_item.byte_count_low[5:0], 2'b00}
                + (r_frame_cnt + 8'd1);
        built[GATE_SUCCESS] = ~r_item.success_flag;
        built[GATE_ERROR]   = ~r_item.error_flag;
        for (int g = GATE_FIRST_SYNC; g < GATE_COUNT; g++) begin
            if (r_item.sync_index != SYNC_NONE &&
                4'(g) == ({2'b00, r_item.sync_index} + SYNC_GATE_BASE)) begin
                built[g] = 1'b0;
            end
        end
        for (int i = 0; i < LED_COUNT; i++) begin
            built[GATE_COUNT + i] =
                (5'(i) < {1'b0, r_item.progress[7:4]}) &&
                ((base + {2'(i), 6'b0}) > (r_phase + PHASE_STEP));
        end
    end

    always_comb begin
        n_in_valid  = r_in_valid;
        n_frame     = r_frame;
        n_left      = r_left;
        n_frame_cnt = r_frame_cnt;
        n_phase     = r_phase;
        if (load) begin
            n_in_valid  = 1'b0;
            n_frame     = built;
            n_left      = LeftW'(FrameW);
            n_frame_cnt = r_frame_cnt + 8'd1;
            n_phase     = r_phase + PHASE_STEP;
        end else if (out_take) begin
            n_frame = r_frame >> 1;
            n_left  = r_left - LeftW'(1);
        end
        if (accept) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_left      <= '0;
            r_frame_cnt <= '0;
            r_phase     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_left      <= n_left;
            r_frame_cnt <= n_frame_cnt;
            r_phase     <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        if (accept) begin
            r_item.progress       <= i_progress;
            r_item.sync_index     <= i_sync_index;
            r_item.byte_count_low <= i_byte_count_low;
            r_item.error_flag     <= i_error_flag;
            r_item.success_flag   <= i_success_flag;
        end
    end

endmodule
